FILE: rtl/ssfb_pkg.sv
// Shared types, codes and the digit glyph table for the segment frame builder.
// No dependencies; imported by every module of the block.
`default_nettype none
package ssfb_pkg;

  localparam int SEG_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_HEX   = 2'd1;
  localparam logic [1:0] MODE_DEC   = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUS = 2'd1;

  localparam logic [7:0] CMD_DATA_SET     = 8'h40;
  localparam logic [7:0] CMD_ADDRESS      = 8'hC0;
  localparam logic [7:0] CMD_CONTROL_BASE = 8'h87;
  localparam logic [7:0] DOT_MASK         = 8'h7F;
  localparam logic [7:0] ERR_MIDDLE       = 8'h50;
  localparam logic [3:0] BRIGHT_MAX       = 4'd8;
  localparam logic [3:0] ERR_BRIGHT       = 4'd7;
  localparam logic [3:0] GLYPH_E          = 4'hE;
  localparam logic [7:0] RESET_BLANK      = 8'h00;
  localparam logic [7:0] RESET_MINUS      = 8'h40;

  localparam logic [2:0] POS_DATA_SET = 3'd0;
  localparam logic [2:0] POS_ADDRESS  = 3'd1;
  localparam logic [2:0] POS_SEG0     = 3'd2;
  localparam logic [2:0] POS_SEG1     = 3'd3;
  localparam logic [2:0] POS_SEG2     = 3'd4;
  localparam logic [2:0] POS_SEG3     = 3'd5;
  localparam logic [2:0] POS_CONTROL  = 3'd6;

  typedef struct packed {
    logic [3:0][7:0] seg;
    logic [7:0]      ctrl;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } head_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0: g = 8'hbf;
      4'h1: g = 8'h86;
      4'h2: g = 8'hdb;
      4'h3: g = 8'hcf;
      4'h4: g = 8'he6;
      4'h5: g = 8'hed;
      4'h6: g = 8'hfd;
      4'h7: g = 8'h87;
      4'h8: g = 8'hff;
      4'h9: g = 8'hef;
      4'hA: g = 8'hf7;
      4'hB: g = 8'hfc;
      4'hC: g = 8'hb9;
      4'hD: g = 8'hde;
      4'hE: g = 8'hf9;
      default: g = 8'hf1;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ssfb_if.sv
// Channel interfaces: update request, wire byte result and register write.
// No dependencies on other files.
`default_nettype none
interface ssfb_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [7:0]        seg_first;
  logic [7:0]        seg_second;
  logic [7:0]        seg_third;
  logic [7:0]        seg_fourth;
  logic              show_dots;
  logic [15:0]       hex_value;
  logic signed [7:0] signed_value;
  logic [3:0]        brightness;
  modport source (output valid, mode, seg_first, seg_second, seg_third, seg_fourth,
                  show_dots, hex_value, signed_value, brightness, input ready);
  modport sink   (input valid, mode, seg_first, seg_second, seg_third, seg_fourth,
                  show_dots, hex_value, signed_value, brightness, output ready);
endinterface

interface ssfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       start_before;
  logic       stop_after;
  logic       last;
  modport source (output valid, wire_byte, start_before, stop_after, last, input ready);
  modport sink   (input valid, wire_byte, start_before, stop_after, last, output ready);
endinterface

interface ssfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ssfb_front.sv
// Front end: accepts update requests, holds the pattern registers and builds
// the segment and control bytes of a frame. Depends on ssfb_pkg, ssfb_if.
`default_nettype none
module ssfb_front
  import ssfb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  ssfb_req_if.sink    req,
  ssfb_cfg_if.sink    cfg,
  input  wire logic   q_full,
  output logic        q_push,
  output frame_t      q_frame
);

  logic [7:0] blank_pattern;
  logic [7:0] minus_pattern;

  logic [7:0] mag;
  logic       hund;
  logic [6:0] rem;
  logic [14:0] tens_prod;
  logic [3:0] tens;
  logic [6:0] tens_x10;
  logic [3:0] ones;
  logic [3:0] bright;
  logic [3:0][7:0] seg;
  logic       keep_dots;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_pattern <= RESET_BLANK;
      minus_pattern <= RESET_MINUS;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BLANK: blank_pattern <= cfg.data;
        CFG_MINUS: minus_pattern <= cfg.data;
        default: ;
      endcase
    end
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  always_comb begin
    mag       = req.signed_value[7] ? (~req.signed_value + 8'd1) : req.signed_value;
    hund      = (mag >= 8'd100);
    rem       = hund ? 7'(mag - 8'd100) : mag[6:0];
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = 7'({tens, 3'b000} + {2'b00, tens, 1'b0});
    ones      = 4'(rem - tens_x10);
  end

  always_comb begin
    keep_dots = 1'b0;
    bright    = req.brightness;
    unique case (req.mode)
      MODE_RAW: begin
        seg       = {req.seg_first, req.seg_second, req.seg_third, req.seg_fourth};
        keep_dots = req.show_dots;
      end
      MODE_HEX: begin
        seg = {glyph(req.hex_value[15:12]), glyph(req.hex_value[11:8]),
               glyph(req.hex_value[7:4]), glyph(req.hex_value[3:0])};
      end
      MODE_DEC: begin
        seg = {req.signed_value[7] ? minus_pattern : blank_pattern,
               glyph({3'b000, hund}), glyph(tens), glyph(ones)};
      end
      default: begin
        seg    = {glyph(GLYPH_E), ERR_MIDDLE, ERR_MIDDLE, blank_pattern};
        bright = ERR_BRIGHT;
      end
    endcase
    if (bright > BRIGHT_MAX) bright = BRIGHT_MAX;
    for (int i = 0; i < 4; i++) begin
      q_frame.seg[i] = keep_dots ? seg[i] : (seg[i] & DOT_MASK);
    end
    q_frame.ctrl = CMD_CONTROL_BASE + {4'b0000, bright};
  end

endmodule
`default_nettype wire

FILE: rtl/ssfb_queue.sv
// Short frame queue between the front end and the byte sequencer.
// Depends on ssfb_pkg for the frame type.
`default_nettype none
module ssfb_queue
  import ssfb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  frame_t    push_frame,
  output logic      full,
  input  wire logic pop,
  output head_t     head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.frame = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ssfb_back.sv
// Byte sequencer: walks the seven wire bytes of the queue head frame into a
// registered result stage. Depends on ssfb_pkg, ssfb_if.
`default_nettype none
module ssfb_back
  import ssfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  head_t      head,
  output logic       pop,
  ssfb_res_if.source res
);

  logic [2:0] pos;
  logic       load;
  logic [7:0] byte_next;
  logic       start_next;
  logic       stop_next;

  assign load = head.valid && (!res.valid || res.ready);
  assign pop  = load && (pos == POS_CONTROL);

  always_comb begin
    start_next = 1'b0;
    stop_next  = 1'b0;
    unique case (pos)
      POS_DATA_SET: begin
        byte_next = CMD_DATA_SET; start_next = 1'b1; stop_next = 1'b1;
      end
      POS_ADDRESS: begin
        byte_next = CMD_ADDRESS; start_next = 1'b1;
      end
      POS_SEG0: byte_next = head.frame.seg[3];
      POS_SEG1: byte_next = head.frame.seg[2];
      POS_SEG2: byte_next = head.frame.seg[1];
      POS_SEG3: begin
        byte_next = head.frame.seg[0]; stop_next = 1'b1;
      end
      default: begin
        byte_next = head.frame.ctrl; start_next = 1'b1; stop_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_DATA_SET;
      res.valid <= 1'b0;
    end else begin
      if (load) begin
        res.valid <= 1'b1;
        pos       <= (pos == POS_CONTROL) ? POS_DATA_SET : pos + 3'd1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.wire_byte    <= byte_next;
      res.start_before <= start_next;
      res.stop_after   <= stop_next;
      res.last         <= (pos == POS_CONTROL);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/seven_segment_serial_frame_builder_core.sv
// Top level of the segment frame builder: front end, frame queue, sequencer.
// Depends on ssfb_pkg, ssfb_if, ssfb_front, ssfb_queue, ssfb_back.
//
//   channel  role   carries
//   req      sink   one display update (mode, raw segs, hex, signed, brightness)
//   res      source one wire byte with start, stop and last flags
//   cfg      sink   register write (index, data); always ready
//
// Each update yields seven result items, one per cycle while the result is not
// stalled; the byte sequencer reading the queue head sets the sustained rate.
// An update is taken while the queue has room; its first byte passes the queue
// slot, then the result register. Reset empties the queue, restarts the
// sequencer and resets the pattern registers. A stalled result holds its output
// register; the queue keeps accepting up to DEPTH frames meanwhile.
`default_nettype none
module seven_segment_serial_frame_builder_core
  import ssfb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input wire logic   clk,
  input wire logic   rst,
  ssfb_req_if.sink   req,
  ssfb_res_if.source res,
  ssfb_cfg_if.sink   cfg
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  frame_t q_frame;
  head_t  q_head;

  ssfb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_frame (q_frame)
  );

  ssfb_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (q_frame),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  ssfb_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (q_head),
    .pop  (q_pop),
    .res  (res)
  );

endmodule
`default_nettype wire
